@@ hdl/lrwq_pkg.sv @@
// shared widths, types and constants of the weight quantizer
package lrwq_pkg;
   localparam int LANES = 4;
   localparam int WEIGHT_W = 16;
   localparam int CLAMP_W = 15;
   localparam int TOTAL_W = 8;
   localparam int SUM_W = 17;
   localparam int PROD_W = 23;
   localparam int QUOT_W = 8;
   localparam int DIV_STAGES = 4;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 8'd255;

   typedef logic [LANES-1:0][QUOT_W-1:0] base_arr_type;
   typedef logic [LANES-1:0][SUM_W-1:0] rem_arr_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic zero;
   } side_type;
endpackage

@@ hdl/lrwq_div_lane.sv @@
// pipelined restoring divider for one lane, two quotient bits per stage
module lrwq_div_lane
   import lrwq_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [PROD_W-1:0] prod_in,
   input  logic [SUM_W-1:0]  sum_in,
   output logic [QUOT_W-1:0] quot_out,
   output logic [SUM_W-1:0]  rem_out
);
   logic [PROD_W-1:0] rem_ff [DIV_STAGES];
   logic [QUOT_W-1:0] quot_ff [DIV_STAGES];
   logic [SUM_W-1:0]  sum_ff [DIV_STAGES];
   logic [PROD_W-1:0] rem_w [DIV_STAGES+1];
   logic [QUOT_W-1:0] quot_w [DIV_STAGES+1];
   logic [SUM_W-1:0]  sum_w [DIV_STAGES+1];

   assign rem_w[0] = prod_in;
   assign quot_w[0] = '0;
   assign sum_w[0] = sum_in;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      localparam int KHI = QUOT_W - 1 - 2 * g;
      logic [PROD_W-1:0] rem_in;
      logic [QUOT_W-1:0] quot_in;

      always_comb begin
         logic [PROD_W+1:0] r;
         logic [PROD_W+1:0] d;
         r = {2'b00, rem_w[g]};
         quot_in = quot_w[g];
         d = (PROD_W+2)'(sum_w[g]) << KHI;
         if (r >= d) begin
            r = r - d;
            quot_in[KHI] = 1'b1;
         end
         d = (PROD_W+2)'(sum_w[g]) << (KHI - 1);
         if (r >= d) begin
            r = r - d;
            quot_in[KHI-1] = 1'b1;
         end
         rem_in = r[PROD_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g] <= rem_in;
            quot_ff[g] <= quot_in;
            sum_ff[g] <= sum_w[g];
         end
      end

      assign rem_w[g+1] = rem_ff[g];
      assign quot_w[g+1] = quot_ff[g];
      assign sum_w[g+1] = sum_ff[g];
   end

   assign quot_out = quot_w[DIV_STAGES];
   assign rem_out = rem_w[DIV_STAGES][SUM_W-1:0];
endmodule

@@ hdl/lrwq_allot.sv @@
// hands out the leftover units by remainder rank and forms the shares; a zero sum gives the total to share 0
module lrwq_allot
   import lrwq_pkg::*;
(
   input  base_arr_type       base,
   input  rem_arr_type        rem,
   input  logic [TOTAL_W-1:0] total,
   input  logic [1:0]         left,
   input  logic               zero,
   output base_arr_type       share
);
   logic [LANES-1:0] elig;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         elig[i] = base[i] < total;
      end
   end

   always_comb begin
      logic [2:0] rank;
      logic give;
      for (int i = 0; i < LANES; i++) begin
         rank = '0;
         for (int j = 0; j < LANES; j++) begin
            if (j != i && elig[j] &&
                (rem[j] > rem[i] || (rem[j] == rem[i] && j < i))) begin
               rank = rank + 3'd1;
            end
         end
         give = elig[i] && (rank < {1'b0, left});
         share[i] = base[i] + QUOT_W'(give);
      end
      if (zero) begin
         share = '0;
         share[0] = total;
      end
   end
endmodule

@@ hdl/largest_remainder_weight_quantizer.sv @@
// top level of the largest-remainder weight quantizer
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_weight_0..3
//  rsp     | out       | rsp_valid, rsp_ready, rsp_share_0..3
//  csr     | in        | csr_write_enable, csr_write_data (weight_total)
// one request per cycle while rsp is not stalled; rsp_valid rises as the request reaches the share register
// the four-stage divider per lane adds to the depth, throughput is one per cycle without stalls
// a stalled rsp freezes the whole pipeline; nothing is lost or repeated
// synchronous reset clears valid bits and sets weight_total to 255
module largest_remainder_weight_quantizer
   import lrwq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_weight_0,
   input  logic signed [15:0] req_weight_1,
   input  logic signed [15:0] req_weight_2,
   input  logic signed [15:0] req_weight_3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_share_0,
   output logic [7:0]         rsp_share_1,
   output logic [7:0]         rsp_share_2,
   output logic [7:0]         rsp_share_3,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data
);
   localparam int DEPTH = DIV_STAGES + 4;

   logic [TOTAL_W-1:0] total_ff;
   logic [DEPTH-1:0]   valid_ff;
   side_type           side_ff [DEPTH];
   logic               enable;

   logic [LANES-1:0][CLAMP_W-1:0] w_in, w_ff;
   logic [SUM_W-1:0]  sum_in, sum_ff, sum2_ff;
   logic [LANES-1:0][PROD_W-1:0] prod_ff;
   base_arr_type      quot_w, base_ff;
   rem_arr_type       rem_w, rem_ff;
   logic [1:0]        left_in, left_ff;
   base_arr_type      share_w, share_ff;
   logic [9:0]        used;
   logic [WEIGHT_W-1:0] raw [LANES];

   assign enable = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
      end else if (csr_write_enable) begin
         total_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
      end
   end

   // clamp and sum
   assign raw[0] = req_weight_0;
   assign raw[1] = req_weight_1;
   assign raw[2] = req_weight_2;
   assign raw[3] = req_weight_3;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         w_in[i] = raw[i][WEIGHT_W-1] ? '0 : raw[i][CLAMP_W-1:0];
         sum_in = sum_in + SUM_W'(w_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         w_ff <= w_in;
         sum_ff <= sum_in;
         side_ff[0] <= '{total: total_ff, zero: sum_in == '0};
         for (int i = 0; i < LANES; i++) begin
            prod_ff[i] <= PROD_W'(w_ff[i]) * PROD_W'(side_ff[0].total);
         end
         sum2_ff <= sum_ff;
         for (int s = 1; s < DEPTH; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      lrwq_div_lane u_div (
         .clock    (clock),
         .enable   (enable),
         .prod_in  (prod_ff[i]),
         .sum_in   (sum2_ff),
         .quot_out (quot_w[i]),
         .rem_out  (rem_w[i])
      );
   end

   // leftover count
   always_comb begin
      used = 10'(quot_w[0]) + 10'(quot_w[1]) + 10'(quot_w[2]) + 10'(quot_w[3]);
      left_in = 2'(10'(side_ff[DEPTH-3].total) - used);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         base_ff <= quot_w;
         rem_ff <= rem_w;
         left_ff <= left_in;
         share_ff <= share_w;
      end
   end

   lrwq_allot u_allot (
      .base  (base_ff),
      .rem   (rem_ff),
      .total (side_ff[DEPTH-2].total),
      .left  (left_ff),
      .zero  (side_ff[DEPTH-2].zero),
      .share (share_w)
   );

   assign rsp_share_0 = share_ff[0];
   assign rsp_share_1 = share_ff[1];
   assign rsp_share_2 = share_ff[2];
   assign rsp_share_3 = share_ff[3];

`ifndef ASSERT_OFF
   a_share_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (10'(rsp_share_0) + 10'(rsp_share_1) + 10'(rsp_share_2)
                     + 10'(rsp_share_3)) == 10'(side_ff[DEPTH-1].total))
      else $error("shares do not add up to the total");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DEPTH-3] && !side_ff[DEPTH-3].zero |->
         used <= 10'(side_ff[DEPTH-3].total) &&
         10'(side_ff[DEPTH-3].total) - used <= 10'd3)
      else $error("leftover out of range");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(valid_ff) && $stable(share_ff))
      else $error("pipeline moved during stall");
`endif
endmodule
